FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Depends on nothing; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

FILE: rtl/nbt_pkg.sv
// Package for the neighbor table: payload structs, opcodes, status codes, register indices.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nbt_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);

  localparam logic [2:0] OpAdd     = 3'd0;
  localparam logic [2:0] OpRemove  = 3'd1;
  localparam logic [2:0] OpFind    = 3'd2;
  localparam logic [2:0] OpSetPar  = 3'd3;
  localparam logic [2:0] OpTick    = 3'd4;
  localparam logic [2:0] OpRefresh = 3'd5;
  localparam logic [2:0] OpRead    = 3'd6;
  localparam logic [2:0] OpClear   = 3'd7;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StFull   = 2'd1;
  localparam logic [1:0] StDup    = 2'd2;
  localparam logic [1:0] StNotFnd = 2'd3;

  localparam logic [1:0] RegLifetime = 2'd0;
  localparam logic [1:0] RegMult     = 2'd1;
  localparam logic [1:0] RegDecr     = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [5:0]  index;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] rank_in;
    logic [15:0] version_in;
    logic [15:0] metric_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [6:0]  entry_count;
    logic        parent_valid;
    logic [5:0]  parent_index;
    logic [63:0] out_addr_high;
    logic [63:0] out_addr_low;
    logic [15:0] out_rank;
    logic [15:0] out_version;
    logic [15:0] out_metric;
    logic        out_is_parent;
    logic [15:0] out_expiry;
  } out_item_t;

  // One table row.
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] rank;
    logic [15:0] version;
    logic [15:0] metric;
    logic        is_parent;
    logic [15:0] expiry;
  } entry_t;

  // Sequencer to memory command.
  typedef struct packed {
    logic           rd_en;
    logic [IdxW-1:0] rd_idx;
    logic           wr_en;
    logic [IdxW-1:0] wr_idx;
    entry_t         wr_data;
  } mem_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/nbt_mem.sv
// Entry store of the neighbor table: one write port, one registered read port.
// Depends on nbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbt_mem (
  input  wire logic              clk_i,
  input  wire nbt_pkg::mem_cmd_t cmd_i,
  output nbt_pkg::entry_t        rd_data_o
);
  nbt_pkg::entry_t mem_q [nbt_pkg::TableDepth];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_idx] <= cmd_i.wr_data;
    if (cmd_i.rd_en) rd_data_o <= mem_q[cmd_i.rd_idx];
  end
endmodule
`default_nettype wire

FILE: rtl/nbt_life.sv
// Lifetime product: default lifetime times multiplier, saturated to 16 bits.
// Registered once; does not depend on nbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbt_life (
  input  wire logic        clk_i,
  input  wire logic [7:0]  lifetime_i,
  input  wire logic [15:0] mult_i,
  output logic      [15:0] life_o
);
  logic [23:0] prod;
  assign prod = 24'(lifetime_i) * 24'(mult_i);
  always_ff @(posedge clk_i) begin
    life_o <= (prod[23:16] != 8'd0) ? 16'hFFFF : prod[15:0];
  end
endmodule
`default_nettype wire

FILE: rtl/neighbor_table_with_aging.sv
// Top level of the neighbor table with aging: sequencer, registers, handshakes.
// Depends on nbt_pkg, nbt_mem, nbt_life and assert_macros.svh.
//
//  channel | direction | handshake               | payload
//  in      | to block  | in_valid_i / in_ready_o | nbt_pkg::in_item_t
//  out     | from block| out_valid_o/ out_ready_i| nbt_pkg::out_item_t
//  cfg     | to block  | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// Add, find, refresh and tick scan the entries one at a time through the memory
// read port; tick moves the last entry into the hole of each expired one. Remove
// moves the last entry into its hole, set parent reads and writes back the entry,
// read fetches one entry; clear and rejected items go straight to the result.
// Reset clears count, preferred parent, lifetime and multiplier and sets the
// decrement to one; entries need no clearing. A finished result waits in
// the output register; the block takes the next item once it is transferred.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module neighbor_table_with_aging (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire nbt_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output nbt_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  localparam int IW = nbt_pkg::IdxW;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] Depth = CW'(nbt_pkg::TableDepth);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SScan  = 4'd1;  // issue read of scan_q
  localparam logic [3:0] SCmp   = 4'd2;  // compare read data
  localparam logic [3:0] SMove  = 4'd3;  // read last entry; SParW writes it into the hole
  localparam logic [3:0] SRdOut = 4'd4;  // read data for read op
  localparam logic [3:0] SDone  = 4'd5;
  localparam logic [3:0] SOut   = 4'd6;
  localparam logic [3:0] SPar   = 4'd7;  // set parent: read, flag, write back
  localparam logic [3:0] SParW  = 4'd8;
  localparam logic [3:0] SRefW  = 4'd9;

  logic [3:0] state_q, state_d;
  nbt_pkg::in_item_t item_q, item_d;
  logic [CW-1:0] count_q, count_d;
  logic pvalid_q, pvalid_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [1:0] status_q, status_d;
  logic [5:0] eidx_q, eidx_d;
  logic rd_q, rd_d;
  logic [7:0] life_cfg_q;
  logic [15:0] mult_q, decr_q;
  nbt_pkg::out_item_t out_q, out_d;
  logic [15:0] life;
  nbt_pkg::mem_cmd_t cmd;
  nbt_pkg::entry_t rdata, new_entry;
  logic scan_end;

  nbt_mem u_mem (.clk_i(clk_i), .cmd_i(cmd), .rd_data_o(rdata));
  nbt_life u_life (.clk_i(clk_i), .lifetime_i(life_cfg_q), .mult_i(mult_q), .life_o(life));

  assign in_ready_o  = (state_q == SIdle);
  assign cfg_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = out_q;
  assign scan_end    = (scan_q >= count_q);

  always_comb begin
    new_entry.addr_high = item_q.addr_high;
    new_entry.addr_low  = item_q.addr_low;
    new_entry.rank      = item_q.rank_in;
    new_entry.version   = item_q.version_in;
    new_entry.metric    = item_q.metric_in;
    new_entry.is_parent = 1'b0;
    new_entry.expiry    = life;
  end

  // Sequencer: every entry access goes through the memory's read and write ports.
  always_comb begin
    logic [CW-1:0] last;
    logic hit;
    state_d = state_q; item_d = item_q; count_d = count_q;
    pvalid_d = pvalid_q; pidx_d = pidx_q; scan_d = scan_q;
    status_d = status_q; eidx_d = eidx_q; rd_d = rd_q;
    cmd = '0;
    cmd.rd_idx = scan_q[IW-1:0];
    cmd.wr_data = rdata;
    last = count_q - CW'(1);
    hit = (rdata.addr_high == item_q.addr_high) && (rdata.addr_low == item_q.addr_low);
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i; status_d = nbt_pkg::StOk; eidx_d = '0; rd_d = 1'b0;
          scan_d = '0;
          unique case (in_data_i.opcode) inside
            nbt_pkg::OpAdd: begin
              if (count_q >= Depth) begin
                status_d = nbt_pkg::StFull; state_d = SDone;
              end else state_d = SScan;
            end
            nbt_pkg::OpFind, nbt_pkg::OpRefresh, nbt_pkg::OpTick: state_d = SScan;
            nbt_pkg::OpRemove, nbt_pkg::OpSetPar, nbt_pkg::OpRead: begin
              scan_d = CW'(in_data_i.index);
              if ({1'b0, in_data_i.index} >= 7'(count_q)) begin
                status_d = nbt_pkg::StNotFnd; state_d = SDone;
                if (in_data_i.opcode == nbt_pkg::OpSetPar) pvalid_d = 1'b0;
              end else if (in_data_i.opcode == nbt_pkg::OpRemove) begin
                state_d = SMove;
                scan_d = CW'(in_data_i.index);
              end else state_d = (in_data_i.opcode == nbt_pkg::OpRead) ? SRdOut : SPar;
            end
            default: begin
              count_d = '0; pvalid_d = 1'b0; state_d = SDone;
            end
          endcase
        end
      end
      SScan: begin
        if (scan_end) begin
          if (item_q.opcode == nbt_pkg::OpAdd) begin
            cmd.wr_en = 1'b1; cmd.wr_idx = count_q[IW-1:0]; cmd.wr_data = new_entry;
            eidx_d = 6'(count_q); count_d = count_q + CW'(1);
          end else if (item_q.opcode != nbt_pkg::OpTick) status_d = nbt_pkg::StNotFnd;
          state_d = SDone;
        end else begin
          cmd.rd_en = 1'b1; state_d = SCmp;
        end
      end
      SCmp: begin
        state_d = SScan;
        if (item_q.opcode == nbt_pkg::OpTick) begin
          if ({1'b0, rdata.expiry} > {1'b0, decr_q}) begin
            cmd.wr_en = 1'b1; cmd.wr_idx = scan_q[IW-1:0];
            cmd.wr_data.expiry = rdata.expiry - decr_q;
            scan_d = scan_q + CW'(1);
          end else state_d = SMove;
        end else if (hit) begin
          // A duplicate add reports index zero.
          if (item_q.opcode == nbt_pkg::OpAdd) begin
            status_d = nbt_pkg::StDup; state_d = SDone;
          end else begin
            eidx_d = 6'(scan_q);
            state_d = (item_q.opcode == nbt_pkg::OpRefresh) ? SRefW : SDone;
          end
        end else scan_d = scan_q + CW'(1);
      end
      // Remove entry scan_q: read last, then write it into the hole.
      SMove: begin
        cmd.rd_en = 1'b1; cmd.rd_idx = last[IW-1:0];
        if (pvalid_q && CW'(pidx_q) == scan_q) pvalid_d = 1'b0;
        else if (pvalid_q && CW'(pidx_q) == last) pidx_d = scan_q[IW-1:0];
        state_d = SParW; rd_d = 1'b1;
      end
      SParW: begin
        if (rd_q) begin
          // move completes
          cmd.wr_en = 1'b1; cmd.wr_idx = scan_q[IW-1:0]; cmd.wr_data = rdata;
          count_d = last; rd_d = 1'b0;
          state_d = (item_q.opcode == nbt_pkg::OpTick) ? SScan : SDone;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_idx = scan_q[IW-1:0];
          cmd.wr_data.is_parent = 1'b1;
          state_d = SDone;
        end
      end
      SPar: begin
        // read issued in SIdle is not possible; issue here and wait
        cmd.rd_en = 1'b1;
        pvalid_d = 1'b1; pidx_d = scan_q[IW-1:0];
        state_d = SRefW; status_d = nbt_pkg::StOk;
      end
      SRefW: begin
        cmd.wr_en = 1'b1; cmd.wr_idx = scan_q[IW-1:0];
        if (item_q.opcode == nbt_pkg::OpRefresh) cmd.wr_data.expiry = life;
        else cmd.wr_data.is_parent = 1'b1;
        state_d = SDone;
      end
      SRdOut: begin
        cmd.rd_en = 1'b1; eidx_d = 6'(scan_q); rd_d = 1'b1; state_d = SDone;
      end
      SDone: state_d = SOut;
      SOut: if (out_ready_i) begin
        state_d = SIdle; rd_d = 1'b0;
      end
      default: state_d = SIdle;
    endcase
  end

  // Build the result once the read data has settled.
  always_comb begin
    out_d = '0;
    out_d.status       = status_q;
    out_d.entry_index  = eidx_q;
    out_d.entry_count  = 7'(count_q);
    out_d.parent_valid = pvalid_q;
    out_d.parent_index = pvalid_q ? 6'(pidx_q) : 6'd0;
    if (rd_q && item_q.opcode == nbt_pkg::OpRead) begin
      out_d.out_addr_high = rdata.addr_high;
      out_d.out_addr_low  = rdata.addr_low;
      out_d.out_rank      = rdata.rank;
      out_d.out_version   = rdata.version;
      out_d.out_metric    = rdata.metric;
      out_d.out_is_parent = rdata.is_parent;
      out_d.out_expiry    = rdata.expiry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SDone) out_q <= out_d;
  end

  always_ff @(posedge clk_i) item_q <= item_d;
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d; status_q <= status_d; eidx_q <= eidx_d; pidx_q <= pidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; count_q <= '0; pvalid_q <= 1'b0; rd_q <= 1'b0;
      life_cfg_q <= '0; mult_q <= '0; decr_q <= 16'd1;
    end else begin
      state_q <= state_d; count_q <= count_d; pvalid_q <= pvalid_d; rd_q <= rd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          nbt_pkg::RegLifetime: life_cfg_q <= cfg_data_i[7:0];
          nbt_pkg::RegMult:     mult_q <= cfg_data_i;
          nbt_pkg::RegDecr:     decr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  `ASSERT_IMPL(a_count_max, clk_i, rst_ni, 1'b1, count_q <= Depth, "count exceeds depth")
  `ASSERT_IMPL(a_parent_in_range, clk_i, rst_ni, pvalid_q, CW'(pidx_q) < count_q,
               "parent index beyond count")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_q),
               "result changed while stalled")
endmodule
`default_nettype wire

FILE: dv/tb_neighbor_table_with_aging.sv
// Self-checking testbench for neighbor_table_with_aging: a directed table, then random
// operation mixes under several register settings, with idling and a long output hold-off.
// Depends on nbt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_neighbor_table_with_aging;
  import nbt_pkg::*;

  localparam int Depth      = TableDepth;
  localparam int HoldCycles = 400;      // long output hold-off to fill the block
  localparam int DrainWait  = 120;      // above the slowest tick of a full table
  localparam int MaxCycles  = 1000000;
  localparam int PoolSize   = 24;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  neighbor_table_with_aging i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Toggle the clock every half period.
  always #4 clk_i = ~clk_i;

  // Table copy kept by the testbench, plus its registers.
  entry_t      nbr_tbl [Depth];
  int unsigned nbr_used;
  bit          par_ok;
  int unsigned par_idx;
  logic [7:0]  life_base;
  logic [15:0] life_mult;
  logic [15:0] tick_step;

  out_item_t   answer_q [$];
  int          n_errors;
  bit          quiet;       // no idling on either side while set
  bit          hold_req;
  bit          hold_done;
  int          hold_left;
  int unsigned cycles;

  logic [63:0] pool_hi [PoolSize];
  logic [63:0] pool_lo [PoolSize];

  function automatic logic [15:0] fresh_expiry();
    int unsigned p;
    p = life_base * life_mult;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic int locate(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < nbr_used; i++)
      if (nbr_tbl[i].addr_high == hi && nbr_tbl[i].addr_low == lo) return i;
    return -1;
  endfunction

  // Move the last entry into the hole; the parent index follows a moved parent and drops a removed one.
  function automatic void evict(int unsigned k);
    int unsigned last;
    if (k >= nbr_used) return;
    last = nbr_used - 1;
    if (par_ok && par_idx == k) par_ok = 1'b0;
    if (par_ok && par_idx == last) par_idx = k;
    nbr_tbl[k] = nbr_tbl[last];
    nbr_used = last;
  endfunction

  function automatic out_item_t apply_op(in_item_t it);
    out_item_t   res;
    int          f;
    int unsigned i;
    res = '0;
    case (it.opcode)
      OpAdd: begin
        if (nbr_used >= Depth) res.status = StFull;
        else if (locate(it.addr_high, it.addr_low) >= 0) res.status = StDup;
        else begin
          nbr_tbl[nbr_used] = '{it.addr_high, it.addr_low, it.rank_in, it.version_in,
                                it.metric_in, 1'b0, fresh_expiry()};
          res.entry_index = nbr_used[5:0];
          nbr_used++;
        end
      end
      OpRemove: begin
        if (it.index >= nbr_used) res.status = StNotFnd;
        else evict(it.index);
      end
      OpFind: begin
        f = locate(it.addr_high, it.addr_low);
        if (f < 0) res.status = StNotFnd;
        else res.entry_index = f[5:0];
      end
      OpSetPar: begin
        if (it.index < nbr_used) begin
          par_ok = 1'b1;
          par_idx = it.index;
          nbr_tbl[it.index].is_parent = 1'b1;
        end else begin
          par_ok = 1'b0;
          res.status = StNotFnd;
        end
      end
      OpTick: begin
        // Age every entry; a removed slot is examined again with its new occupant.
        i = 0;
        while (i < nbr_used) begin
          if (nbr_tbl[i].expiry > tick_step) begin
            nbr_tbl[i].expiry = nbr_tbl[i].expiry - tick_step;
            i++;
          end else evict(i);
        end
      end
      OpRefresh: begin
        f = locate(it.addr_high, it.addr_low);
        if (f < 0) res.status = StNotFnd;
        else begin
          res.entry_index = f[5:0];
          nbr_tbl[f].expiry = fresh_expiry();
        end
      end
      OpRead: begin
        if (it.index < nbr_used) begin
          res.entry_index   = it.index;
          res.out_addr_high = nbr_tbl[it.index].addr_high;
          res.out_addr_low  = nbr_tbl[it.index].addr_low;
          res.out_rank      = nbr_tbl[it.index].rank;
          res.out_version   = nbr_tbl[it.index].version;
          res.out_metric    = nbr_tbl[it.index].metric;
          res.out_is_parent = nbr_tbl[it.index].is_parent;
          res.out_expiry    = nbr_tbl[it.index].expiry;
        end else res.status = StNotFnd;
      end
      default: begin
        nbr_used = 0;
        par_ok = 1'b0;
      end
    endcase
    res.entry_count  = nbr_used[6:0];
    res.parent_valid = par_ok;
    res.parent_index = par_ok ? par_idx[5:0] : 6'd0;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", field, got, want, $realtime);
    n_errors++;
  endtask

  task automatic compare_result(out_item_t got, out_item_t want);
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
    if (got.entry_index !== want.entry_index)
      report_mismatch("entry_index", got.entry_index, want.entry_index);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", got.entry_count, want.entry_count);
    if (got.parent_valid !== want.parent_valid)
      report_mismatch("parent_valid", got.parent_valid, want.parent_valid);
    if (got.parent_index !== want.parent_index)
      report_mismatch("parent_index", got.parent_index, want.parent_index);
    if (got.out_addr_high !== want.out_addr_high)
      report_mismatch("out_addr_high", got.out_addr_high, want.out_addr_high);
    if (got.out_addr_low !== want.out_addr_low)
      report_mismatch("out_addr_low", got.out_addr_low, want.out_addr_low);
    if (got.out_rank !== want.out_rank) report_mismatch("out_rank", got.out_rank, want.out_rank);
    if (got.out_version !== want.out_version)
      report_mismatch("out_version", got.out_version, want.out_version);
    if (got.out_metric !== want.out_metric)
      report_mismatch("out_metric", got.out_metric, want.out_metric);
    if (got.out_is_parent !== want.out_is_parent)
      report_mismatch("out_is_parent", got.out_is_parent, want.out_is_parent);
    if (got.out_expiry !== want.out_expiry)
      report_mismatch("out_expiry", got.out_expiry, want.out_expiry);
  endtask

  // Output side: check each transfer against the oldest answer, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) report_mismatch("unexpected result", '0, '0);
        else compare_result(out_data_o, answer_q.pop_front());
      end
      // Start the one long hold-off when asked.
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else out_ready_i <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item, hold it until the transfer, then record its answer.
  // A typed answer overrides the status and count that the table copy gives.
  task automatic send_item(in_item_t it, bit typed = 1'b0,
                           logic [1:0] st = StOk, logic [6:0] cnt = '0);
    out_item_t want;
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    want = apply_op(it);
    if (typed) begin
      want.status = st;
      want.entry_count = cnt;
    end
    answer_q.push_back(want);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegLifetime: life_base = val[7:0];
      RegMult:     life_mult = val;
      RegDecr:     tick_step = val;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every answer, then let a tick finish before touching registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic [2:0] op, logic [5:0] idx,
                                         logic [63:0] hi, logic [63:0] lo);
    in_item_t it;
    it = '{op, idx, hi, lo, 16'($urandom), 16'($urandom), 16'($urandom)};
    return it;
  endfunction

  function automatic in_item_t random_item();
    int          w;
    int          p;
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [63:0] hi;
    logic [63:0] lo;
    w = $urandom_range(99);
    if (w < 30) op = OpAdd;
    else if (w < 40) op = OpRemove;
    else if (w < 52) op = OpFind;
    else if (w < 62) op = OpSetPar;
    else if (w < 76) op = OpTick;
    else if (w < 86) op = OpRefresh;
    else if (w < 98) op = OpRead;
    else op = OpClear;
    // Mostly indexes from zero to just past the table size, sometimes the full field.
    idx = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(0, Depth + 1));
    p = $urandom_range(0, PoolSize - 1);
    if ($urandom_range(9) == 0) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end else begin
      hi = pool_hi[p];
      lo = pool_lo[p];
    end
    return make_item(op, idx, hi, lo);
  endfunction

  typedef struct {
    in_item_t   it;
    bit         typed;
    logic [1:0] st;
    logic [6:0] cnt;
  } stim_row_t;

  stim_row_t rows [$];

  initial begin
    logic [63:0] ones;
    n_errors = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    nbr_used = 0;
    par_ok = 1'b0;
    par_idx = 0;
    life_base = '0;
    life_mult = '0;
    tick_step = 16'd1;
    ones = '1;
    pool_hi[0] = '0;
    pool_lo[0] = '0;
    pool_hi[1] = ones;
    pool_lo[1] = ones;
    for (int i = 2; i < PoolSize; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = (i % 3 == 0) ? pool_lo[i - 1] : {$urandom, $urandom};
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Errors on an empty table, then the basic life of an entry.
    rows.push_back('{make_item(OpRead, 6'd0, '0, '0), 1'b1, StNotFnd, 7'd0});
    rows.push_back('{make_item(OpRemove, 6'd63, '0, '0), 1'b1, StNotFnd, 7'd0});
    rows.push_back('{make_item(OpFind, 6'd0, '0, '0), 1'b1, StNotFnd, 7'd0});
    rows.push_back('{make_item(OpRefresh, 6'd0, ones, ones), 1'b1, StNotFnd, 7'd0});
    rows.push_back('{make_item(OpSetPar, 6'd0, '0, '0), 1'b1, StNotFnd, 7'd0});
    rows.push_back('{make_item(OpTick, 6'd0, '0, '0), 1'b1, StOk, 7'd0});
    rows.push_back('{'{OpAdd, 6'd63, ones, ones, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                     1'b1, StOk, 7'd1});
    rows.push_back('{make_item(OpAdd, 6'd0, ones, ones), 1'b1, StDup, 7'd1});
    rows.push_back('{'{OpAdd, 6'd0, 64'd0, 64'd0, 16'd0, 16'd0, 16'd0}, 1'b1, StOk, 7'd2});
    rows.push_back('{make_item(OpFind, 6'd0, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpSetPar, 6'd1, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpRead, 6'd1, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpRead, 6'd0, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpRefresh, 6'd0, ones, ones), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpRead, 6'd2, '0, '0), 1'b1, StNotFnd, 7'd2});
    // Remove the entry ahead of the parent: the parent follows into the hole.
    rows.push_back('{make_item(OpRemove, 6'd0, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpTick, 6'd0, '0, '0), 1'b0, StOk, 7'd0});
    rows.push_back('{make_item(OpSetPar, 6'd40, '0, '0), 1'b1, StNotFnd, 7'd1});
    rows.push_back('{make_item(OpClear, 6'd0, '0, '0), 1'b1, StOk, 7'd0});

    // Saturating lifetime for the directed part.
    write_reg(RegLifetime, 16'd255);
    write_reg(RegMult, 16'd300);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].st, rows[i].cnt);

    // Fill the table, mark the last entry as parent, then hit the full case.
    for (int i = 0; i < Depth; i++)
      send_item(make_item(OpAdd, '0, 64'hA5, {$urandom, 26'($urandom), 6'(i)}));
    send_item(make_item(OpSetPar, 6'(Depth - 1), '0, '0));
    send_item(make_item(OpAdd, '0, ones, '0), 1'b1, StFull, 7'(Depth));
    send_item(make_item(OpRemove, 6'd3, '0, '0));
    send_item(make_item(OpRemove, 6'd3, '0, '0));
    settle();

    // Random phases: one per register setting, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(RegLifetime, 16'd0);   write_reg(RegMult, 16'd0);
                 write_reg(RegDecr, 16'd1); end
        1: begin write_reg(RegLifetime, 16'd255); write_reg(RegMult, 16'hFFFF);
                 write_reg(RegDecr, 16'hFFFF); end
        2: begin write_reg(RegLifetime, 16'd4);   write_reg(RegMult, 16'd3);
                 write_reg(RegDecr, 16'd2); end
        3: begin write_reg(RegLifetime, 16'd9);   write_reg(RegMult, 16'd1);
                 write_reg(RegDecr, 16'd0); end
        4: begin write_reg(RegLifetime, 16'd200); write_reg(RegMult, 16'd2);
                 write_reg(RegDecr, 16'd57); end
        default: begin write_reg(2'd3, 16'hFFFF); write_reg(RegLifetime, 16'd1);
                 write_reg(RegMult, 16'd6); write_reg(RegDecr, 16'd1); end
      endcase
      // Phase 2 gets the long hold-off; phase 4 runs without idling.
      hold_req = (ph == 2);
      quiet = (ph == 4);
      for (int n = 0; n < 175; n++) send_item(random_item());
      settle();
      quiet = 1'b0;
    end

    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/nbt_pkg.sv
rtl/nbt_mem.sv
rtl/nbt_life.sv
rtl/neighbor_table_with_aging.sv
dv/tb_neighbor_table_with_aging.sv
